FILE: design/tlsr_pkg.sv
// ----------------------------------------------------------------------------
// tlsr_pkg
// Shared types and constants of the thick line span rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsr_pkg;

  localparam int unsigned RADIUS_BITS = 5;
  localparam int unsigned LIM_BITS    = 4;
  localparam int unsigned SQ_BITS     = 9;
  localparam int unsigned LEN_BITS    = 6;
  localparam int unsigned COLOR_BITS  = 16;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 5'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_line;  // item with mode 0 accepted: load or reject the line
    logic setup;       // latch pen, radius and step the line state
    logic walk;        // walk the fill, a candidate a cycle unless output stalls
    logic flush;       // move the held span out as the item's last result
    logic mark;        // put a done marker out
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;       // an endpoint of the offered line lies below the radius
    logic line_active;  // a line has stamps left
    logic out_free;     // output register can take a result this cycle
    logic walk_end;     // final candidate of the circle fill retires this cycle
  } sts_t;

  // Octant limit of the circle fill: floor(r * 707 / 1000) + 1.
  function automatic logic [LIM_BITS-1:0] lim_of(input logic [RADIUS_BITS-1:0] r);
    logic [LIM_BITS-1:0] lim;
    lim = 4'd1;
    unique case (r)
      5'd1:  lim = 4'd1;
      5'd2:  lim = 4'd2;
      5'd3:  lim = 4'd3;
      5'd4:  lim = 4'd3;
      5'd5:  lim = 4'd4;
      5'd6:  lim = 4'd5;
      5'd7:  lim = 4'd5;
      5'd8:  lim = 4'd6;
      5'd9:  lim = 4'd7;
      5'd10: lim = 4'd8;
      5'd11: lim = 4'd8;
      5'd12: lim = 4'd9;
      5'd13: lim = 4'd10;
      5'd14: lim = 4'd10;
      5'd15: lim = 4'd11;
      5'd16: lim = 4'd12;
      5'd17: lim = 4'd13;
      5'd18: lim = 4'd13;
      5'd19: lim = 4'd14;
      5'd20: lim = 4'd15;
      5'd21: lim = 4'd15;
      default: lim = 4'd1;
    endcase
    return lim;
  endfunction

endpackage

`default_nettype wire

FILE: design/tlsr_in_if.sv
// ----------------------------------------------------------------------------
// tlsr_in_if
// Input item channel: line endpoints, color and mode with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlsr_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic [COORD_BITS-1:0]            start_x;
  logic [COORD_BITS-1:0]            start_y;
  logic [COORD_BITS-1:0]            end_x;
  logic [COORD_BITS-1:0]            end_y;
  logic [tlsr_pkg::COLOR_BITS-1:0]  pen_color;

  modport source (
    output valid, mode, start_x, start_y, end_x, end_y, pen_color,
    input  ready
  );

  modport sink (
    input  valid, mode, start_x, start_y, end_x, end_y, pen_color,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/tlsr_out_if.sv
// ----------------------------------------------------------------------------
// tlsr_out_if
// Result item channel: one horizontal span or a done marker with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlsr_out_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                             valid;
  logic                             ready;
  logic                             span_valid;
  logic [COORD_BITS-1:0]            span_x;
  logic [COORD_BITS-1:0]            span_y;
  logic [tlsr_pkg::LEN_BITS-1:0]    span_length;
  logic [tlsr_pkg::COLOR_BITS-1:0]  span_color;
  logic                             stamp_last;
  logic                             line_done;

  modport source (
    output valid, span_valid, span_x, span_y, span_length, span_color,
           stamp_last, line_done,
    input  ready
  );

  modport sink (
    input  valid, span_valid, span_x, span_y, span_length, span_color,
           stamp_last, line_done,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/tlsr_ctrl.sv
// ----------------------------------------------------------------------------
// tlsr_ctrl
// Item sequencer: accepts an item, then runs setup, fill walk and flush,
// or puts out a done marker.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  logic             item_mode_i,
  output logic             item_ready_o,
  input  tlsr_pkg::sts_t   sts_i,
  output tlsr_pkg::cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_WALK  = 5'b00100,
    S_FLUSH = 5'b01000,
    S_MARK  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign item_ready_o = (state_q == S_IDLE);
  assign accept       = item_valid_i && item_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!item_mode_i) begin
            state_d = sts_i.reject ? S_MARK : S_SETUP;
          end else begin
            state_d = sts_i.line_active ? S_SETUP : S_MARK;
          end
        end
      end
      S_SETUP: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (sts_i.walk_end) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      S_MARK: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.start_line = accept && !item_mode_i;
    cmd_o.setup      = (state_q == S_SETUP);
    cmd_o.walk       = (state_q == S_WALK);
    cmd_o.flush      = (state_q == S_FLUSH);
    cmd_o.mark       = (state_q == S_MARK);
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !item_ready_o)
    else $error("item accepted but sequencer still idle next cycle");

  a_walk_end_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.walk_end |-> (state_q == S_WALK))
    else $error("fill walk ended outside the walk state");

  a_advance_idle_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && item_mode_i && !sts_i.line_active) |=> (state_q == S_MARK))
    else $error("advance without a line did not produce a done marker");
`endif

endmodule

`default_nettype wire

FILE: design/tlsr_dpath.sv
// ----------------------------------------------------------------------------
// tlsr_dpath
// Line state, circle fill walker, held span and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsr_dpath #(
  parameter int unsigned MAX_RADIUS = 21,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tlsr_pkg::RADIUS_BITS-1:0]     cfg_wdata_i,
  input  tlsr_pkg::cmd_t                       cmd_i,
  output tlsr_pkg::sts_t                       sts_o,
  input  logic [COORD_BITS-1:0]                start_x_i,
  input  logic [COORD_BITS-1:0]                start_y_i,
  input  logic [COORD_BITS-1:0]                end_x_i,
  input  logic [COORD_BITS-1:0]                end_y_i,
  input  logic [tlsr_pkg::COLOR_BITS-1:0]      pen_color_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 span_valid_o,
  output logic [COORD_BITS-1:0]                span_x_o,
  output logic [COORD_BITS-1:0]                span_y_o,
  output logic [tlsr_pkg::LEN_BITS-1:0]        span_length_o,
  output logic [tlsr_pkg::COLOR_BITS-1:0]      span_color_o,
  output logic                                 stamp_last_o,
  output logic                                 line_done_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned RB = tlsr_pkg::RADIUS_BITS;
  localparam int unsigned LB = tlsr_pkg::LIM_BITS;
  localparam int unsigned SB = tlsr_pkg::SQ_BITS;
  localparam int unsigned NB = tlsr_pkg::LEN_BITS;
  localparam logic [RB-1:0] RadMax = RB'(MAX_RADIUS);

  typedef enum logic [1:0] {
    SL_TOP  = 2'd0,  // cap row below center, x rows
    SL_BOT  = 2'd1,  // cap row above center, x rows
    SL_ROWP = 2'd2,  // body row below center, i rows
    SL_ROWN = 2'd3   // body row above center, i rows
  } slot_e;

  // ---------------- radius register ----------------
  logic [RB-1:0] rad_cfg_q;
  logic [RB-1:0] rad;
  logic [CB-1:0] rad_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_cfg_q <= tlsr_pkg::RADIUS_RESET;
    end else if (cfg_we_i) begin
      rad_cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    rad = rad_cfg_q;
    if (rad_cfg_q == '0) begin
      rad = RB'(1);
    end else if (rad_cfg_q > RadMax) begin
      rad = RadMax;
    end
  end

  assign rad_ext = {{(CB-RB){1'b0}}, rad};

  // ---------------- line state ----------------
  logic [CB-1:0]                     pen_col_q, pen_row_q;
  logic [CB-1:0]                     adx_q, ady_q, major_q;
  logic [CB-1:0]                     col_err_q, row_err_q;
  logic [3:0]                        dirs_q;
  logic [CB:0]                       stamps_left_q;
  logic [tlsr_pkg::COLOR_BITS-1:0]   color_q;
  logic                              active_q;

  logic          reject;
  logic          dx_pos, dx_neg, dy_pos, dy_neg;
  logic [CB-1:0] adx, ady, major;
  logic [CB:0]   col_sum, row_sum;
  logic          col_step, row_step;
  logic [CB-1:0] col_err_d, row_err_d, pen_col_d, pen_row_d;

  assign reject = (start_x_i < rad_ext) || (end_x_i < rad_ext) ||
                  (start_y_i < rad_ext) || (end_y_i < rad_ext);

  assign dx_pos = end_x_i > start_x_i;
  assign dx_neg = end_x_i < start_x_i;
  assign dy_pos = end_y_i > start_y_i;
  assign dy_neg = end_y_i < start_y_i;
  assign adx    = dx_pos ? (end_x_i - start_x_i) : (start_x_i - end_x_i);
  assign ady    = dy_pos ? (end_y_i - start_y_i) : (start_y_i - end_y_i);
  assign major  = (adx > ady) ? adx : ady;

  // Error terms stay at or below the major distance, so the sum fits CB+1 bits.
  assign col_sum   = {1'b0, col_err_q} + {1'b0, adx_q};
  assign row_sum   = {1'b0, row_err_q} + {1'b0, ady_q};
  assign col_step  = col_sum > {1'b0, major_q};
  assign row_step  = row_sum > {1'b0, major_q};
  assign col_err_d = col_step ? CB'(col_sum - {1'b0, major_q}) : col_sum[CB-1:0];
  assign row_err_d = row_step ? CB'(row_sum - {1'b0, major_q}) : row_sum[CB-1:0];

  always_comb begin
    pen_col_d = pen_col_q;
    pen_row_d = pen_row_q;
    if (col_step && dirs_q[0]) begin
      pen_col_d = dirs_q[1] ? (pen_col_q - CB'(1)) : (pen_col_q + CB'(1));
    end
    if (row_step && dirs_q[2]) begin
      pen_row_d = dirs_q[3] ? (pen_row_q - CB'(1)) : (pen_row_q + CB'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_col_q     <= '0;
      pen_row_q     <= '0;
      adx_q         <= '0;
      ady_q         <= '0;
      major_q       <= '0;
      col_err_q     <= '0;
      row_err_q     <= '0;
      dirs_q        <= '0;
      stamps_left_q <= '0;
      color_q       <= '0;
      active_q      <= 1'b0;
    end else if (cmd_i.start_line) begin
      active_q <= !reject;
      if (!reject) begin
        pen_col_q     <= start_x_i;
        pen_row_q     <= start_y_i;
        adx_q         <= adx;
        ady_q         <= ady;
        major_q       <= major;
        col_err_q     <= '0;
        row_err_q     <= '0;
        dirs_q        <= {dy_neg, dy_pos || dy_neg, dx_neg, dx_pos || dx_neg};
        stamps_left_q <= {1'b0, major} + (CB+1)'(2);
        color_q       <= pen_color_i;
      end
    end else if (cmd_i.setup) begin
      // Step the pen after latching the stamp center below.
      pen_col_q <= pen_col_d;
      pen_row_q <= pen_row_d;
      col_err_q <= col_err_d;
      row_err_q <= row_err_d;
      if (stamps_left_q != '0) stamps_left_q <= stamps_left_q - (CB+1)'(1);
      active_q  <= stamps_left_q > (CB+1)'(1);
    end
  end

  // ---------------- circle fill walker ----------------
  logic [CB-1:0] cx_q, cy_q;
  logic [LB-1:0] lim_q, i_q;
  logic [RB-1:0] x_q;
  logic [SB-1:0] sq_q;
  slot_e         slot_q;
  logic          cond_q;
  logic          done_q;

  logic [2*RB-1:0] rr_full;
  logic [2*RB-1:0] sq_full;
  logic [2*LB-1:0] ii;
  logic [2*RB-1:0] xx;
  logic [2*RB-1:0] sum_sq;
  logic            cond_now;
  logic            big_x;
  logic [CB-1:0]   i_ext, x_ext;
  logic [CB-1:0]   cand_x, cand_y;
  logic [NB-1:0]   cand_len;
  logic [NB-1:0]   cap_len;
  logic            cand_nz;
  logic            out_free;
  logic            walk_adv;
  logic            push;

  assign rr_full = {{RB{1'b0}}, rad} * {{RB{1'b0}}, rad};
  assign sq_full = rr_full + {{(RB+1){1'b0}}, rad[RB-1:1]};

  assign ii       = {{LB{1'b0}}, i_q} * {{LB{1'b0}}, i_q};
  assign xx       = {{RB{1'b0}}, x_q} * {{RB{1'b0}}, x_q};
  assign sum_sq   = {{(2*RB-2*LB){1'b0}}, ii} + xx;
  assign cond_now = sum_sq > {{(2*RB-SB){1'b0}}, sq_q};
  assign big_x    = x_q > {{(RB-LB){1'b0}}, lim_q};

  assign i_ext   = {{(CB-LB){1'b0}}, i_q};
  assign x_ext   = {{(CB-RB){1'b0}}, x_q};
  assign cap_len = {1'b0, i_q - LB'(1), 1'b0};

  always_comb begin
    cand_x   = cx_q - x_ext;
    cand_y   = cy_q + i_ext;
    cand_len = {x_q, 1'b0};
    unique case (slot_q)
      SL_TOP: begin
        cand_x   = cx_q - i_ext + CB'(1);
        cand_y   = cy_q + x_ext;
        cand_len = (cond_now && big_x) ? cap_len : '0;
      end
      SL_BOT: begin
        cand_x   = cx_q - i_ext + CB'(1);
        cand_y   = cy_q - x_ext;
        cand_len = (cond_q && big_x) ? cap_len : '0;
      end
      SL_ROWP: begin
        cand_x   = cx_q - x_ext;
        cand_y   = cy_q + i_ext;
        cand_len = {x_q, 1'b0};
      end
      SL_ROWN: begin
        cand_x   = cx_q - x_ext;
        cand_y   = cy_q - i_ext;
        cand_len = {x_q, 1'b0};
      end
      default: begin
        cand_len = '0;
      end
    endcase
  end

  // Held span: a span leaves only once a later one exists, so the last span
  // of the stamp can carry its flag.
  logic            pend_valid_q;
  logic [CB-1:0]   pend_x_q, pend_y_q;
  logic [NB-1:0]   pend_len_q;

  logic            out_valid_q;

  assign cand_nz  = (cand_len != '0);
  assign out_free = !out_valid_q || out_ready_i;
  assign walk_adv = cmd_i.walk && (!cand_nz || !pend_valid_q || out_free);
  assign push     = cmd_i.walk && cand_nz && pend_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q    <= '0;
      x_q    <= '0;
      slot_q <= SL_TOP;
      cond_q <= 1'b0;
    end else if (cmd_i.setup) begin
      i_q    <= LB'(1);
      x_q    <= rad;
      slot_q <= SL_TOP;
      cond_q <= 1'b0;
    end else if (walk_adv) begin
      unique case (slot_q)
        SL_TOP: begin
          cond_q <= cond_now;
          slot_q <= SL_BOT;
        end
        SL_BOT: begin
          if (cond_q && (x_q != '0)) x_q <= x_q - RB'(1);
          slot_q <= SL_ROWP;
        end
        SL_ROWP: begin
          slot_q <= SL_ROWN;
        end
        SL_ROWN: begin
          i_q    <= i_q + LB'(1);
          slot_q <= SL_TOP;
        end
        default: begin
          slot_q <= SL_TOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      cx_q   <= pen_col_q;
      cy_q   <= pen_row_q;
      lim_q  <= tlsr_pkg::lim_of(rad);
      sq_q   <= sq_full[SB-1:0];
      done_q <= stamps_left_q <= (CB+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.setup) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush && out_free) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      // Center row of the stamp.
      pend_x_q   <= pen_col_q - rad_ext;
      pend_y_q   <= pen_row_q;
      pend_len_q <= {rad, 1'b0};
    end else if (walk_adv && cand_nz) begin
      pend_x_q   <= cand_x;
      pend_y_q   <= cand_y;
      pend_len_q <= cand_len;
    end
  end

  // ---------------- output register ----------------
  logic                             load_out;
  logic                             span_valid_q;
  logic [CB-1:0]                    out_x_q, out_y_q;
  logic [NB-1:0]                    out_len_q;
  logic [tlsr_pkg::COLOR_BITS-1:0]  out_color_q;
  logic                             out_last_q;
  logic                             out_done_q;

  assign load_out = ((cmd_i.mark || cmd_i.flush) && out_free) || push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark && out_free) begin
      span_valid_q <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_len_q    <= '0;
      out_color_q  <= '0;
      out_last_q   <= 1'b1;
      out_done_q   <= 1'b1;
    end else if (load_out) begin
      span_valid_q <= 1'b1;
      out_x_q      <= pend_x_q;
      out_y_q      <= pend_y_q;
      out_len_q    <= pend_len_q;
      out_color_q  <= color_q;
      out_last_q   <= cmd_i.flush;
      out_done_q   <= done_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign span_valid_o  = span_valid_q;
  assign span_x_o      = out_x_q;
  assign span_y_o      = out_y_q;
  assign span_length_o = out_len_q;
  assign span_color_o  = out_color_q;
  assign stamp_last_o  = out_last_q;
  assign line_done_o   = out_done_q;

  always_comb begin
    sts_o             = '0;
    sts_o.reject      = reject;
    sts_o.line_active = active_q;
    sts_o.out_free    = out_free;
    sts_o.walk_end    = walk_adv && (slot_q == SL_ROWN) && (i_q == lim_q);
  end

`ifndef ASSERT_OFF
  a_pend_during_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> pend_valid_q)
    else $error("fill walk running without a held span");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> ((i_q != '0) && (i_q <= lim_q)))
    else $error("fill row index left the octant range");

  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !span_valid_q) |-> (out_last_q && out_done_q && (out_len_q == '0)))
    else $error("done marker carries span data or misses its flags");
`endif

endmodule

`default_nettype wire

FILE: design/thick_line_span_rasterizer.sv
// Output: a stamp's spans pass through the held span and the output register;
//   at radius 1 every fill row is empty, so the center row leaves at the flush.
// Items: a new item is taken only after the last one is flushed or marked. The fill
//   walks rows 1 to L = floor(radius*707/1000)+1, one span candidate a cycle unless
//   the output stalls. A rejected line or an advance with no line: one done marker.
// Reset: asynchronous, active low; radius back to 2, no line active.
// ----------------------------------------------------------------------------
// thick_line_span_rasterizer
// Draws a thick line as round brush stamps along a Bresenham-style path and
// hands out each stamp as horizontal spans.
// ----------------------------------------------------------------------------
`default_nettype none

module thick_line_span_rasterizer #(
  parameter int unsigned MAX_RADIUS = 21,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tlsr_pkg::RADIUS_BITS-1:0]  cfg_wdata_i,
  tlsr_in_if.sink                           item_i,
  tlsr_out_if.source                        span_o
);

  // Controller and datapath talk only through these two bundles.
  tlsr_pkg::cmd_t cmd;
  tlsr_pkg::sts_t sts;
  logic           item_ready;

  // Sequence each item: accept, setup, walk the fill, flush; or put out a done marker.
  tlsr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_mode_i  (item_i.mode),
    .item_ready_o (item_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Hold the line state and radius, generate spans, drive the result register.
  tlsr_dpath #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .start_x_i     (item_i.start_x),
    .start_y_i     (item_i.start_y),
    .end_x_i       (item_i.end_x),
    .end_y_i       (item_i.end_y),
    .pen_color_i   (item_i.pen_color),
    .out_valid_o   (span_o.valid),
    .out_ready_i   (span_o.ready),
    .span_valid_o  (span_o.span_valid),
    .span_x_o      (span_o.span_x),
    .span_y_o      (span_o.span_y),
    .span_length_o (span_o.span_length),
    .span_color_o  (span_o.span_color),
    .stamp_last_o  (span_o.stamp_last),
    .line_done_o   (span_o.line_done)
  );

  // Take a new item only between items; the result register decouples output.
  assign item_i.ready = item_ready;

endmodule

`default_nettype wire

FILE: verif/tb_thick_line_span_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thick_line_span_rasterizer
// Self-checking bench for the thick line span rasterizer. A built-in span
// predictor follows every accepted line item and queues the spans and done
// markers it should produce. Each span leaving the block is compared field by
// field with the oldest queued one. Directed cases come first: the brush
// limits, rejected lines, wrap at the top of the coordinate range, and brush
// changes in the middle of a line. Random lines follow under three patterns
// of sender and receiver stalls.
// ----------------------------------------------------------------------------

module tb_thick_line_span_rasterizer;

  localparam int unsigned RADIUS_BITS  = tlsr_pkg::RADIUS_BITS;
  localparam int unsigned LEN_BITS     = tlsr_pkg::LEN_BITS;
  localparam int unsigned COLOR_BITS   = tlsr_pkg::COLOR_BITS;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = tlsr_pkg::RADIUS_RESET;

  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned MAX_RADIUS   = 21;
  localparam int unsigned MAX_SPANS    = 61;
  localparam int unsigned OCTANT_NUM   = 707;
  localparam int unsigned OCTANT_DEN   = 1000;
  localparam int unsigned COORD_MAX    = 65535;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned REPORT_LIMIT = 40;

  // Item modes
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Bit positions in the step direction flags
  localparam int DIR_COL_MOVES = 0;
  localparam int DIR_COL_NEG   = 1;
  localparam int DIR_ROW_MOVES = 2;
  localparam int DIR_ROW_NEG   = 3;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                  mode;
    coord_t                start_x;
    coord_t                start_y;
    coord_t                end_x;
    coord_t                end_y;
    logic [COLOR_BITS-1:0] pen_color;
  } line_item_t;

  typedef struct packed {
    logic                  span_valid;
    coord_t                span_x;
    coord_t                span_y;
    logic [LEN_BITS-1:0]   span_length;
    logic [COLOR_BITS-1:0] span_color;
    logic                  stamp_last;
    logic                  line_done;
  } span_rec_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [RADIUS_BITS-1:0] cfg_wdata;

  tlsr_in_if  #(.COORD_BITS(COORD_BITS)) item_if ();
  tlsr_out_if #(.COORD_BITS(COORD_BITS)) span_if ();

  thick_line_span_rasterizer #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if.sink),
    .span_o      (span_if.source)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the line walker and the brush register
  // --------------------------------------------------------------------------
  logic [RADIUS_BITS-1:0] brush_radius;
  coord_t                 pen_col;
  coord_t                 pen_row;
  logic [16:0]            abs_dx;
  logic [16:0]            abs_dy;
  logic [16:0]            major_dist;
  logic [17:0]            col_err;
  logic [17:0]            row_err;
  logic [17:0]            stamps_left;
  logic [3:0]             step_dirs;
  logic [COLOR_BITS-1:0]  line_color;
  logic                   line_active;

  span_rec_t expected_spans[$];  // spans still owed by the block, oldest first
  span_rec_t stamp_spans[$];     // scratch list for the stamp being built

  // Stall knobs, in percent of cycles
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // Run statistics
  int unsigned items_sent;
  int unsigned spans_checked;
  int unsigned done_markers;
  int unsigned lines_finished;
  int unsigned radius_writes;
  int unsigned error_count;
  int unsigned cycle_count;

  // --------------------------------------------------------------------------
  // Span predictor
  // --------------------------------------------------------------------------

  // Clamp the register to the brush sizes the block supports.
  function automatic int unsigned eff_radius();
    int unsigned r;
    r = brush_radius;
    if (r == 0) r = 1;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    return r;
  endfunction

  // Drop empty spans; the stamp never holds more than MAX_SPANS.
  function automatic void add_span(coord_t x, coord_t y, int unsigned len);
    span_rec_t s;
    if (len == 0 || stamp_spans.size() >= MAX_SPANS) return;
    s.span_valid  = 1'b1;
    s.span_x      = x;
    s.span_y      = y;
    s.span_length = len[LEN_BITS-1:0];
    s.span_color  = line_color;
    s.stamp_last  = 1'b0;
    s.line_done   = 1'b0;
    stamp_spans.push_back(s);
  endfunction

  // Integer circle fill around (cx, cy): the center row, then row pairs above
  // and below, with cap rows added once the octant limit is passed.
  function automatic void draw_stamp(coord_t cx, coord_t cy);
    int unsigned r, lim, sq, x;
    r   = eff_radius();
    lim = r * OCTANT_NUM / OCTANT_DEN + 1;
    sq  = r * r + r / 2;
    x   = r;
    stamp_spans.delete();
    add_span(coord_t'(cx - r), cy, 2 * r);
    for (int unsigned i = 1; i <= lim; i++) begin
      if (i * i + x * x > sq) begin
        if (x > lim) begin
          add_span(coord_t'(cx - i + 1), coord_t'(cy + x), 2 * (i - 1));
          add_span(coord_t'(cx - i + 1), coord_t'(cy - x), 2 * (i - 1));
        end
        if (x > 0) x--;
      end
      add_span(coord_t'(cx - x), coord_t'(cy + i), 2 * x);
      add_span(coord_t'(cx - x), coord_t'(cy - i), 2 * x);
    end
  endfunction

  function automatic void push_done_marker();
    span_rec_t s;
    s            = '0;
    s.stamp_last = 1'b1;
    s.line_done  = 1'b1;
    expected_spans.push_back(s);
    done_markers++;
  endfunction

  // Stamp at the pen, then step the error terms and the pen.
  function automatic void emit_stamp();
    draw_stamp(pen_col, pen_row);
    col_err = col_err + abs_dx;
    row_err = row_err + abs_dy;
    // The step is taken only when the error is strictly above the distance.
    if (col_err > major_dist) begin
      col_err = col_err - major_dist;
      if (step_dirs[DIR_COL_MOVES])
        pen_col = step_dirs[DIR_COL_NEG] ? pen_col - 1'b1 : pen_col + 1'b1;
    end
    if (row_err > major_dist) begin
      row_err = row_err - major_dist;
      if (step_dirs[DIR_ROW_MOVES])
        pen_row = step_dirs[DIR_ROW_NEG] ? pen_row - 1'b1 : pen_row + 1'b1;
    end
    if (stamps_left != 0) stamps_left--;
    if (stamps_left == 0) begin
      line_active = 1'b0;
      lines_finished++;
    end
    if (stamp_spans.size() > 0) stamp_spans[$].stamp_last = 1'b1;
    foreach (stamp_spans[k]) begin
      stamp_spans[k].line_done = !line_active;
      expected_spans.push_back(stamp_spans[k]);
    end
  endfunction

  // Work out everything one accepted item should produce.
  function automatic void rasterize_item(line_item_t it);
    int unsigned r;
    if (it.mode == MODE_ADVANCE) begin
      if (!line_active) push_done_marker();
      else emit_stamp();
      return;
    end
    r           = eff_radius();
    line_active = 1'b0;
    // Reject the line when any endpoint coordinate is below the brush radius.
    if (it.start_x < r || it.end_x < r || it.start_y < r || it.end_y < r) begin
      push_done_marker();
      return;
    end
    step_dirs = '0;
    if (it.end_x > it.start_x) begin
      abs_dx                   = {1'b0, it.end_x - it.start_x};
      step_dirs[DIR_COL_MOVES] = 1'b1;
    end else if (it.end_x < it.start_x) begin
      abs_dx                   = {1'b0, it.start_x - it.end_x};
      step_dirs[DIR_COL_MOVES] = 1'b1;
      step_dirs[DIR_COL_NEG]   = 1'b1;
    end else begin
      abs_dx = '0;
    end
    if (it.end_y > it.start_y) begin
      abs_dy                   = {1'b0, it.end_y - it.start_y};
      step_dirs[DIR_ROW_MOVES] = 1'b1;
    end else if (it.end_y < it.start_y) begin
      abs_dy                   = {1'b0, it.start_y - it.end_y};
      step_dirs[DIR_ROW_MOVES] = 1'b1;
      step_dirs[DIR_ROW_NEG]   = 1'b1;
    end else begin
      abs_dy = '0;
    end
    major_dist  = (abs_dx > abs_dy) ? abs_dx : abs_dy;
    pen_col     = it.start_x;
    pen_row     = it.start_y;
    col_err     = '0;
    row_err     = '0;
    stamps_left = major_dist + 18'd2;
    line_color  = it.pen_color;
    line_active = 1'b1;
    emit_stamp();
  endfunction

  // --------------------------------------------------------------------------
  // Clock, receiver stalls, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Redraw ready at every falling edge so stalls land on every phase of a stamp.
  initial begin
    span_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      span_if.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit hit, %0d spans still owed", $time,
               expected_spans.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted span against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    span_rec_t got;
    span_rec_t want;
    if (rst_n && span_if.valid === 1'b1 && span_if.ready === 1'b1) begin
      got.span_valid  = span_if.span_valid;
      got.span_x      = span_if.span_x;
      got.span_y      = span_if.span_y;
      got.span_length = span_if.span_length;
      got.span_color  = span_if.span_color;
      got.stamp_last  = span_if.stamp_last;
      got.line_done   = span_if.line_done;
      if (expected_spans.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: unexpected span, expected none, actual %h", $time, got);
      end else begin
        want = expected_spans.pop_front();
        check_field("span_valid", want.span_valid, got.span_valid);
        check_field("span_x", want.span_x, got.span_x);
        check_field("span_y", want.span_y, got.span_y);
        check_field("span_length", want.span_length, got.span_length);
        check_field("span_color", want.span_color, got.span_color);
        check_field("stamp_last", want.stamp_last, got.stamp_last);
        check_field("line_done", want.line_done, got.line_done);
      end
      spans_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Drive one item at the falling edge, hold it until accepted, then predict.
  task automatic send_item(line_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_if.valid = 1'b0;
      @(negedge clk);
    end
    item_if.mode      = it.mode;
    item_if.start_x   = it.start_x;
    item_if.start_y   = it.start_y;
    item_if.end_x     = it.end_x;
    item_if.end_y     = it.end_y;
    item_if.pen_color = it.pen_color;
    item_if.valid     = 1'b1;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    rasterize_item(it);
    items_sent++;
  endtask

  // Drop valid, hold until every owed span is out, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    item_if.valid = 1'b0;
    while (expected_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Brush writes only happen with the block drained.
  task automatic set_brush_radius(logic [RADIUS_BITS-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = RADIUS_BITS'($urandom);
    brush_radius = value;
    radius_writes++;
  endtask

  function automatic line_item_t start_item(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                            logic [COLOR_BITS-1:0] color);
    line_item_t it;
    it.mode      = MODE_START;
    it.start_x   = sx;
    it.start_y   = sy;
    it.end_x     = ex;
    it.end_y     = ey;
    it.pen_color = color;
    return it;
  endfunction

  // Endpoint and color fields are don't-care on an advance; fill them with noise.
  function automatic line_item_t advance_item();
    line_item_t it;
    it.start_x   = coord_t'($urandom);
    it.start_y   = coord_t'($urandom);
    it.end_x     = coord_t'($urandom);
    it.end_y     = coord_t'($urandom);
    it.pen_color = COLOR_BITS'($urandom);
    it.mode      = MODE_ADVANCE;
    return it;
  endfunction

  // Legal coordinate for brush r, biased toward both ends of the range.
  function automatic coord_t pick_coord(int unsigned r);
    case ($urandom_range(3))
      0:       return coord_t'(r + $urandom_range(30));
      1:       return coord_t'(COORD_MAX - $urandom_range(30));
      default: return coord_t'($urandom_range(COORD_MAX, r));
    endcase
  endfunction

  // Endpoint d away from s in a random direction, kept legal for brush r.
  function automatic coord_t pick_end(coord_t s, int unsigned d, int unsigned r);
    bit up_ok, down_ok;
    up_ok   = (s + d <= COORD_MAX);
    down_ok = (s >= r + d);
    if (up_ok && (!down_ok || $urandom_range(1))) return coord_t'(s + d);
    return coord_t'(s - d);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Advance straight out of reset: no line yet, so a lone done marker.
  task automatic test_advance_without_line();
    send_item(advance_item());
  endtask

  // Reset brush of 2: walk a short line to its end, then one advance too many.
  task automatic test_default_brush_line();
    send_item(start_item(16'd10, 16'd10, 16'd13, 16'd11, 16'hA5A5));
    repeat (5) send_item(advance_item());
  endtask

  // Brush of 0 acts as 1, brushes above the maximum act as the maximum.
  // The widest brush at the top corner wraps the rows past the range end.
  task automatic test_brush_clamping();
    set_brush_radius('0);
    send_item(start_item(16'd1, 16'd1, 16'd1, 16'd1, 16'h0000));
    send_item(advance_item());
    set_brush_radius('1);
    send_item(start_item(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFE, 16'hFFFF));
    repeat (2) send_item(advance_item());
    set_brush_radius(RADIUS_BITS'(MAX_RADIUS + 1));
    send_item(start_item(16'd21, 16'd21, 16'd21, 16'd22, 16'h5A5A));
  endtask

  // One endpoint coordinate below the brush at a time, then an advance on
  // the dead line.
  task automatic test_rejected_lines();
    send_item(start_item(16'd20, 16'd100, 16'd100, 16'd100, 16'h1234));
    send_item(start_item(16'd100, 16'd0, 16'd100, 16'd100, 16'h1234));
    send_item(start_item(16'd100, 16'd100, 16'd20, 16'd100, 16'h1234));
    send_item(start_item(16'd100, 16'd100, 16'd100, 16'd0, 16'h1234));
    send_item(advance_item());
  endtask

  // Each stamp takes the brush current at its own item.
  task automatic test_brush_change_midline();
    set_brush_radius(RADIUS_BITS'(1));
    send_item(start_item(16'd50, 16'd50, 16'd47, 16'd54, 16'hC3C3));
    set_brush_radius(RADIUS_BITS'(MAX_RADIUS));
    send_item(advance_item());
    set_brush_radius(RADIUS_BITS'(5));
    send_item(advance_item());
  endtask

  // Mostly complete short lines, plus long lines left unfinished, rejected
  // lines, fully random items and brush changes between lines.
  task automatic test_random_lines(int unsigned n_items, int unsigned tx_pct,
                                   int unsigned rx_pct);
    int unsigned base_count, choice, r, d_major, d_minor, n_adv, roll;
    coord_t      sx, sy, ex, ey;
    line_item_t  it;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    base_count  = items_sent;
    while (items_sent - base_count < n_items) begin
      choice = $urandom_range(99);
      r      = eff_radius();
      if (choice < 8) begin
        // New brush, one of the limits four times in six
        case ($urandom_range(5))
          0:       set_brush_radius('0);
          1:       set_brush_radius(RADIUS_BITS'(1));
          2:       set_brush_radius(RADIUS_BITS'(MAX_RADIUS));
          3:       set_brush_radius('1);
          default: set_brush_radius(RADIUS_BITS'($urandom_range(31)));
        endcase
      end else if (choice < 14) begin
        // Noise: every field random, the mode too
        it.start_x   = coord_t'($urandom);
        it.start_y   = coord_t'($urandom);
        it.end_x     = coord_t'($urandom);
        it.end_y     = coord_t'($urandom);
        it.pen_color = COLOR_BITS'($urandom);
        it.mode      = 1'($urandom_range(1));
        send_item(it);
      end else if (choice < 20) begin
        // Rejected line: push one coordinate under the brush
        sx = pick_coord(r);
        sy = pick_coord(r);
        ex = pick_coord(r);
        ey = pick_coord(r);
        case ($urandom_range(3))
          0:       sx = coord_t'($urandom_range(r - 1));
          1:       sy = coord_t'($urandom_range(r - 1));
          2:       ex = coord_t'($urandom_range(r - 1));
          default: ey = coord_t'($urandom_range(r - 1));
        endcase
        send_item(start_item(sx, sy, ex, ey, COLOR_BITS'($urandom)));
        if ($urandom_range(1)) send_item(advance_item());
      end else if (choice < 27) begin
        // Long line: draw a few stamps, then abandon it
        send_item(start_item(pick_coord(r), pick_coord(r), pick_coord(r), pick_coord(r),
                             COLOR_BITS'($urandom)));
        repeat ($urandom_range(4)) send_item(advance_item());
      end else begin
        // Short line, usually walked to its end
        d_major = $urandom_range(10);
        d_minor = $urandom_range(d_major);
        sx      = pick_coord(r);
        sy      = pick_coord(r);
        if ($urandom_range(1)) begin
          ex = pick_end(sx, d_major, r);
          ey = pick_end(sy, d_minor, r);
        end else begin
          ex = pick_end(sx, d_minor, r);
          ey = pick_end(sy, d_major, r);
        end
        send_item(start_item(sx, sy, ex, ey, COLOR_BITS'($urandom)));
        n_adv = d_major + 1;
        roll  = $urandom_range(99);
        if (roll < 15) n_adv = $urandom_range(n_adv);
        else if (roll < 30) n_adv += $urandom_range(2, 1);
        repeat (n_adv) send_item(advance_item());
        // Now and then hold the sender until every span is out
        if ($urandom_range(9) == 0) wait_idle();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    item_if.valid     = 1'b0;
    item_if.mode      = MODE_START;
    item_if.start_x   = '0;
    item_if.start_y   = '0;
    item_if.end_x     = '0;
    item_if.end_y     = '0;
    item_if.pen_color = '0;

    brush_radius = RADIUS_RESET;
    pen_col      = '0;
    pen_row      = '0;
    abs_dx       = '0;
    abs_dy       = '0;
    major_dist   = '0;
    col_err      = '0;
    row_err      = '0;
    stamps_left  = '0;
    step_dirs    = '0;
    line_color   = '0;
    line_active  = 1'b0;

    items_sent     = 0;
    spans_checked  = 0;
    done_markers   = 0;
    lines_finished = 0;
    radius_writes  = 0;
    error_count    = 0;
    cycle_count    = 0;
    tx_idle_pct    = 10;
    rx_idle_pct    = 53;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_advance_without_line();
    test_default_brush_line();
    test_brush_clamping();
    test_rejected_lines();
    test_brush_change_midline();

    test_random_lines(103, 10, 53);
    test_random_lines(103, 53, 10);
    test_random_lines(103, 0, 0);

    wait_idle();
    repeat (20) @(posedge clk);

    $display("Ran %0d line items, checked %0d results, %0d of them done markers.",
             items_sent, spans_checked, done_markers);
    $display("Drew %0d lines to their last stamp across %0d brush writes; %0d mismatches.",
             lines_finished, radius_writes, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/tlsr_pkg.sv
design/tlsr_in_if.sv
design/tlsr_out_if.sv
design/tlsr_ctrl.sv
design/tlsr_dpath.sv
design/thick_line_span_rasterizer.sv
verif/tb_thick_line_span_rasterizer.sv
